@@ design/tsm_pkg.sv @@
// shared constants, types and helpers of the tdm slot level meter
`timescale 1ns / 1ps

package tsm_pkg;

  localparam int MAX_SLOTS  = 8;
  localparam int SLOT_W     = 3;
  localparam int SCOUNT_W   = 4;
  localparam int SAMPLE_W   = 16;
  localparam int SQ_W       = 50;
  localparam int PROD_W     = 32;
  localparam int PEAK_W     = 16;
  localparam int CNT_W      = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW     = 2'd1;

  localparam logic [SCOUNT_W-1:0] SLOT_COUNT_RESET = 4'd4;
  localparam logic [CNT_W-1:0]    WINDOW_RESET     = 20'd48000;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [SQ_W-1:0]  SQ_MAX  = {SQ_W{1'b1}};

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SQUARE = 4'b0010,
    ST_ACCUM  = 4'b0100,
    ST_REPORT = 4'b1000
  } tsm_state_t;

  // one slot's accumulator set
  typedef struct packed {
    logic [SQ_W-1:0]   square_sum;
    logic [PEAK_W-1:0] peak;
    logic [CNT_W-1:0]  crossings;
    logic              prev_neg;
  } tsm_entry_t;

  // controls from the sequencer to the datapath
  typedef struct packed {
    logic              load_sample;
    logic              do_square;
    logic              write_entry;
    logic              clear_all;
    logic              load_out;
    logic              out_last;
    logic [SLOT_W-1:0] addr;
  } tsm_ctl_t;

  // zero means one slot, anything above the maximum saturates
  function automatic logic [SCOUNT_W-1:0] tsm_slots_in_use(input logic [SCOUNT_W-1:0] cnt);
    logic [SCOUNT_W-1:0] n;
    n = cnt;
    if (n == '0) begin
      n = SCOUNT_W'(1);
    end
    if (n > SCOUNT_W'(MAX_SLOTS)) begin
      n = SCOUNT_W'(MAX_SLOTS);
    end
    return n;
  endfunction

endpackage

@@ design/tsm_if.sv @@
// handshake channel interfaces: samples in, report lines out, register writes
`timescale 1ns / 1ps

interface tsm_sample_if;
  import tsm_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface tsm_report_if;
  import tsm_pkg::*;
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] slot_index;
  logic [SQ_W-1:0]   square_sum;
  logic [PEAK_W-1:0] peak_magnitude;
  logic [CNT_W-1:0]  crossing_count;
  logic              last_of_report;
  modport source (output valid, output slot_index, output square_sum, output peak_magnitude,
                  output crossing_count, output last_of_report, input ready);
  modport sink   (input valid, input slot_index, input square_sum, input peak_magnitude,
                  input crossing_count, input last_of_report, output ready);
endinterface

interface tsm_cfg_if;
  import tsm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/tdm_slot_level_meter_core.sv @@
// top level of the tdm slot level meter: registers, output stage, submodules
//
// samples: one signed 16-bit sample per transfer, slots interleaved in frame
//   order; the block tracks the slot position itself.
// reports: at the end of every window_frames frames, one line per slot in use
//   (slot index, sum of squares, peak magnitude, sign-change count), the final
//   line flagged by last_of_report.
// cfg: register writes (0 slot_count, 1 window_frames), always ready; write
//   only while no sample is in flight and no report is pending.
// timing: a sample is accepted, squared in the next cycle and accumulated in
//   the one after; samples ready stays low until the accumulate is done, so
//   no new sample is taken before the last is through the single multiply/accumulate unit.
// at a window end the report lines are walked in slot order, each loaded into
//   the output register when it is free, after the accumulate of the last sample.
// if reports stalls, the line holds in the output register and the walk over
//   the slots waits; no samples are taken until the last line is registered.
// reset (rst, synchronous) clears all accumulators, signs, slot and frame
//   counts and restores slot_count 4 and window_frames 48000 at once.
`timescale 1ns / 1ps

module tdm_slot_level_meter_core
  import tsm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  tsm_sample_if.sink          samples,
  tsm_report_if.source        reports,
  tsm_cfg_if.sink             cfg
);

  logic [SCOUNT_W-1:0] slot_count;
  logic [CNT_W-1:0]    window_frames;
  tsm_ctl_t            ctl;
  tsm_entry_t          rd_entry;
  tsm_entry_t          wr_entry;
  logic                out_free;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count    <= SLOT_COUNT_RESET;
      window_frames <= WINDOW_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_SLOT_COUNT: slot_count    <= cfg.data[SCOUNT_W-1:0];
        REG_WINDOW:     window_frames <= cfg.data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_free = !reports.valid || reports.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      reports.valid <= 1'b0;
    end else if (ctl.load_out) begin
      reports.valid <= 1'b1;
    end else if (reports.ready) begin
      reports.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      reports.slot_index     <= ctl.addr;
      reports.square_sum     <= rd_entry.square_sum;
      reports.peak_magnitude <= rd_entry.peak;
      reports.crossing_count <= rd_entry.crossings;
      reports.last_of_report <= ctl.out_last;
    end
  end

  tsm_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (samples.valid),
    .in_ready      (samples.ready),
    .out_free      (out_free),
    .slot_count    (slot_count),
    .window_frames (window_frames),
    .ctl           (ctl)
  );

  tsm_arith u_arith (
    .clk      (clk),
    .ctl      (ctl),
    .raw      (samples.sample),
    .rd_entry (rd_entry),
    .wr_entry (wr_entry)
  );

  tsm_bank u_bank (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .wr_entry (wr_entry),
    .rd_entry (rd_entry)
  );

endmodule

@@ design/tsm_arith.sv @@
// shared arithmetic unit: magnitude, square and saturating accumulator update
`timescale 1ns / 1ps

module tsm_arith
  import tsm_pkg::*;
(
  input  logic                clk,
  input  tsm_ctl_t            ctl,
  input  logic [SAMPLE_W-1:0] raw,
  input  tsm_entry_t          rd_entry,
  output tsm_entry_t          wr_entry
);

  logic [PEAK_W-1:0] mag;
  logic              neg;
  logic [PROD_W-1:0] product;
  logic [SQ_W:0]     sum;

  always_ff @(posedge clk) begin
    if (ctl.load_sample) begin
      neg <= raw[SAMPLE_W-1];
      mag <= raw[SAMPLE_W-1] ? (~raw + SAMPLE_W'(1)) : raw;
    end
    if (ctl.do_square) begin
      product <= {16'b0, mag} * {16'b0, mag};
    end
  end

  always_comb begin
    sum = {1'b0, rd_entry.square_sum} + {{(SQ_W + 1 - PROD_W){1'b0}}, product};
    wr_entry.square_sum = sum[SQ_W] ? SQ_MAX : sum[SQ_W-1:0];
    wr_entry.peak       = (mag > rd_entry.peak) ? mag : rd_entry.peak;
    wr_entry.crossings  = rd_entry.crossings;
    if (neg != rd_entry.prev_neg && rd_entry.crossings != CNT_MAX) begin
      wr_entry.crossings = rd_entry.crossings + CNT_W'(1);
    end
    wr_entry.prev_neg = neg;
  end

endmodule

@@ design/tsm_bank.sv @@
// per-slot accumulator registers with one addressed read/write port and clear
`timescale 1ns / 1ps

module tsm_bank
  import tsm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  tsm_ctl_t   ctl,
  input  tsm_entry_t wr_entry,
  output tsm_entry_t rd_entry
);

  logic [SQ_W-1:0]   square_sums [MAX_SLOTS];
  logic [PEAK_W-1:0] peaks       [MAX_SLOTS];
  logic [CNT_W-1:0]  crossings   [MAX_SLOTS];
  logic              prev_negs   [MAX_SLOTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_SLOTS; i++) begin
        square_sums[i] <= '0;
        peaks[i]       <= '0;
        crossings[i]   <= '0;
        prev_negs[i]   <= 1'b0;
      end
    end else if (ctl.clear_all) begin
      // signs survive the end of a window
      for (int i = 0; i < MAX_SLOTS; i++) begin
        square_sums[i] <= '0;
        peaks[i]       <= '0;
        crossings[i]   <= '0;
      end
    end else if (ctl.write_entry) begin
      square_sums[ctl.addr] <= wr_entry.square_sum;
      peaks[ctl.addr]       <= wr_entry.peak;
      crossings[ctl.addr]   <= wr_entry.crossings;
      prev_negs[ctl.addr]   <= wr_entry.prev_neg;
    end
  end

  always_comb begin
    rd_entry.square_sum = square_sums[ctl.addr];
    rd_entry.peak       = peaks[ctl.addr];
    rd_entry.crossings  = crossings[ctl.addr];
    rd_entry.prev_neg   = prev_negs[ctl.addr];
  end

endmodule

@@ design/tsm_ctrl.sv @@
// sequencer: slot and frame tracking, per-sample steps and report line walk
`timescale 1ns / 1ps

module tsm_ctrl
  import tsm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                out_free,
  input  logic [SCOUNT_W-1:0] slot_count,
  input  logic [CNT_W-1:0]    window_frames,
  output tsm_ctl_t            ctl
);

  tsm_state_t          state, state_next;
  logic [SLOT_W-1:0]   slot_position;
  logic [SLOT_W-1:0]   report_idx;
  logic [CNT_W-1:0]    frame_counter;
  logic [CNT_W-1:0]    frame_next;
  logic [SCOUNT_W-1:0] n;
  logic                frame_end;
  logic                report_due;
  logic                line_last;

  assign n          = tsm_slots_in_use(slot_count);
  assign frame_end  = ({1'b0, slot_position} + SCOUNT_W'(1)) >= n;
  assign frame_next = (frame_counter != CNT_MAX) ? frame_counter + CNT_W'(1) : frame_counter;
  assign report_due = frame_next >= window_frames;
  assign line_last  = ({1'b0, report_idx} + SCOUNT_W'(1)) == n;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    ctl.load_sample = (state == ST_IDLE) && in_valid;
    ctl.do_square   = (state == ST_SQUARE);
    ctl.write_entry = (state == ST_ACCUM);
    ctl.load_out    = (state == ST_REPORT) && out_free;
    ctl.out_last    = line_last;
    // accumulators clear on the same edge that takes the final line
    ctl.clear_all   = ctl.load_out && line_last;
    ctl.addr        = (state == ST_REPORT) ? report_idx : slot_position;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_SQUARE;
        end
      end
      ST_SQUARE: state_next = ST_ACCUM;
      ST_ACCUM: begin
        state_next = (frame_end && report_due) ? ST_REPORT : ST_IDLE;
      end
      ST_REPORT: begin
        if (out_free && line_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      slot_position <= '0;
      frame_counter <= '0;
      report_idx    <= '0;
    end else begin
      state <= state_next;
      if (state == ST_ACCUM) begin
        if (frame_end) begin
          slot_position <= '0;
          frame_counter <= report_due ? '0 : frame_next;
          report_idx    <= '0;
        end else begin
          slot_position <= slot_position + SLOT_W'(1);
        end
      end
      if (ctl.load_out && !line_last) begin
        report_idx <= report_idx + SLOT_W'(1);
      end
    end
  end

endmodule

@@ tb/tdm_slot_level_meter_core_tb.sv @@
// self-checking testbench of the tdm slot level meter: predicted report lines vs the block
`timescale 1ns / 1ps

module tdm_slot_level_meter_core_tb;
  import tsm_pkg::*;

  localparam int SETTLE = 10;
  localparam int DRAIN  = 40;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef enum logic {
    ITEM_SAMPLE,
    ITEM_WRITE
  } item_kind_t;

  typedef struct {
    item_kind_t            kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [SAMPLE_W-1:0]   smp;
  } item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [SQ_W-1:0]   sq;
    logic [PEAK_W-1:0] peak;
    logic [CNT_W-1:0]  crossings;
    logic              last;
  } line_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tsm_sample_if samples_ch ();
  tsm_report_if reports_ch ();
  tsm_cfg_if    cfg_ch ();

  tdm_slot_level_meter_core DUT (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_ch),
    .reports (reports_ch),
    .cfg     (cfg_ch)
  );

  always #2 clk = ~clk;

  item_t pending_items[$];
  line_t expected_lines[$];

  // meter state as the block should hold it
  logic [SCOUNT_W-1:0] cfg_slots;
  logic [CNT_W-1:0]    cfg_window;
  int unsigned         slot_pos;
  logic [CNT_W-1:0]    frame_cnt;
  logic [63:0]         acc_sq[MAX_SLOTS];
  logic [16:0]         acc_peak[MAX_SLOTS];
  logic [CNT_W-1:0]    acc_cross[MAX_SLOTS];
  bit                  prev_neg[MAX_SLOTS];

  int errors    = 0;
  int n_samples = 0;
  int n_writes  = 0;
  int n_lines   = 0;
  int quiet     = 0;
  bit calm      = 1'b0;

  task automatic meter_reset();
    cfg_slots  = SLOT_COUNT_RESET;
    cfg_window = WINDOW_RESET;
    slot_pos   = 0;
    frame_cnt  = '0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      acc_sq[i]    = '0;
      acc_peak[i]  = '0;
      acc_cross[i] = '0;
      prev_neg[i]  = 1'b0;
    end
  endtask

  task automatic meter_write_reg(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] data);
    if (idx == REG_SLOT_COUNT) begin
      cfg_slots = data[SCOUNT_W-1:0];
    end else if (idx == REG_WINDOW) begin
      cfg_window = data[CNT_W-1:0];
    end
  endtask

  // accumulate one sample, queue the report lines of a window end
  task automatic meter_take_sample(input logic [SAMPLE_W-1:0] smp);
    logic        neg;
    logic [16:0] mag;
    logic [63:0] sq;
    int unsigned n;
    int unsigned s;
    line_t       ln;
    neg = smp[SAMPLE_W-1];
    mag = neg ? (17'h10000 - {1'b0, smp}) : {1'b0, smp};
    n = (cfg_slots == 0) ? 1 : ((cfg_slots > MAX_SLOTS) ? MAX_SLOTS : cfg_slots);
    s = (slot_pos >= MAX_SLOTS) ? MAX_SLOTS - 1 : slot_pos;
    sq = acc_sq[s] + 64'(mag) * 64'(mag);
    acc_sq[s] = (sq > 64'(SQ_MAX)) ? 64'(SQ_MAX) : sq;
    if (mag > acc_peak[s]) begin
      acc_peak[s] = mag;
    end
    if (neg != prev_neg[s] && acc_cross[s] < CNT_MAX) begin
      acc_cross[s] = acc_cross[s] + 1'b1;
    end
    prev_neg[s] = neg;
    if (s + 1 >= n) begin
      slot_pos = 0;
      if (frame_cnt < CNT_MAX) begin
        frame_cnt = frame_cnt + 1'b1;
      end
      if (frame_cnt >= cfg_window) begin
        for (int i = 0; i < n; i++) begin
          ln.slot      = SLOT_W'(i);
          ln.sq        = acc_sq[i][SQ_W-1:0];
          ln.peak      = acc_peak[i][15:0] | (acc_peak[i][16] ? 16'h8000 : 16'h0000);
          ln.crossings = acc_cross[i];
          ln.last      = (i + 1 == n);
          expected_lines.push_back(ln);
        end
        frame_cnt = '0;
        // every slot is cleared, in use or not; signs survive
        for (int i = 0; i < MAX_SLOTS; i++) begin
          acc_sq[i]    = '0;
          acc_peak[i]  = '0;
          acc_cross[i] = '0;
        end
      end
    end else begin
      slot_pos = s + 1;
    end
  endtask

  function automatic void check_field(string what, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t mismatch %s: expected %h actual %h", $time, what, want, got);
      errors++;
    end
  endfunction

  task automatic push_sample(input logic [SAMPLE_W-1:0] v);
    item_t it;
    it.kind = ITEM_SAMPLE;
    it.idx  = '0;
    it.data = '0;
    it.smp  = v;
    pending_items.push_back(it);
  endtask

  task automatic push_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    item_t it;
    it.kind = ITEM_WRITE;
    it.idx  = idx;
    it.data = data;
    it.smp  = '0;
    pending_items.push_back(it);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    logic [SAMPLE_W-1:0] v;
    case ($urandom_range(9))
      0: v = 16'h7FFF;
      1: v = 16'h8000;
      2: v = 16'h0000;
      3: v = 16'hFFFF;
      4, 5: begin
        v = SAMPLE_W'($urandom_range(15));
        if ($urandom_range(1) == 1) begin
          v = -v;
        end
      end
      default: v = SAMPLE_W'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic [SCOUNT_W-1:0] pick_slots();
    logic [SCOUNT_W-1:0] v;
    case ($urandom_range(9))
      0: v = 4'd0;
      1: v = SCOUNT_W'($urandom_range(MAX_SLOTS + 1, 15));
      2: v = 4'd1;
      3: v = SCOUNT_W'(MAX_SLOTS);
      default: v = SCOUNT_W'($urandom_range(1, MAX_SLOTS));
    endcase
    return v;
  endfunction

  function automatic logic [CNT_W-1:0] pick_window();
    logic [CNT_W-1:0] v;
    if ($urandom_range(19) == 0) begin
      v = CNT_MAX;
    end else begin
      case ($urandom_range(5))
        0: v = '0;
        1: v = CNT_W'($urandom_range(4, 10));
        default: v = CNT_W'($urandom_range(1, 3));
      endcase
    end
    return v;
  endfunction

  // sample and register driver
  always @(posedge clk) begin
    logic  s_take;
    logic  w_take;
    logic  s_valid_n;
    logic  w_valid_n;
    logic  idle;
    item_t it;
    s_take = samples_ch.valid && samples_ch.ready;
    w_take = cfg_ch.valid && cfg_ch.ready;
    if (rst) begin
      samples_ch.valid <= 1'b0;
      cfg_ch.valid     <= 1'b0;
    end else begin
      if (s_take) begin
        meter_take_sample(samples_ch.sample);
        n_samples++;
      end
      if (w_take) begin
        meter_write_reg(cfg_ch.index, cfg_ch.data);
        n_writes++;
      end
      calm = (n_samples >= 110 && n_samples < 170);
      if (samples_ch.valid || reports_ch.valid || expected_lines.size() != 0) begin
        quiet = 0;
      end else if (quiet < 1000) begin
        quiet++;
      end
      s_valid_n = samples_ch.valid && !s_take;
      w_valid_n = cfg_ch.valid && !w_take;
      idle = !calm && ($urandom_range(99) < 34);
      if (!s_valid_n && !w_valid_n && pending_items.size() != 0 && !idle) begin
        it = pending_items[0];
        if (it.kind == ITEM_SAMPLE) begin
          s_valid_n = 1'b1;
          samples_ch.sample <= it.smp;
          void'(pending_items.pop_front());
        end else if (quiet >= SETTLE) begin
          // registers change only once the block has gone idle
          w_valid_n = 1'b1;
          cfg_ch.index <= it.idx;
          cfg_ch.data  <= it.data;
          void'(pending_items.pop_front());
        end
      end
      samples_ch.valid <= s_valid_n;
      cfg_ch.valid     <= w_valid_n;
    end
  end

  // report line monitor
  always @(posedge clk) begin
    line_t want;
    if (rst) begin
      reports_ch.ready <= 1'b0;
    end else begin
      if (reports_ch.valid && reports_ch.ready) begin
        n_lines++;
        if (expected_lines.size() == 0) begin
          $display("%0t unexpected report line: slot %0d sum %h peak %h crossings %h last %b",
                   $time, reports_ch.slot_index, reports_ch.square_sum,
                   reports_ch.peak_magnitude, reports_ch.crossing_count,
                   reports_ch.last_of_report);
          errors++;
        end else begin
          want = expected_lines.pop_front();
          check_field("slot_index", 64'(want.slot), 64'(reports_ch.slot_index));
          check_field("square_sum", 64'(want.sq), 64'(reports_ch.square_sum));
          check_field("peak_magnitude", 64'(want.peak), 64'(reports_ch.peak_magnitude));
          check_field("crossing_count", 64'(want.crossings), 64'(reports_ch.crossing_count));
          check_field("last_of_report", 64'(want.last), 64'(reports_ch.last_of_report));
        end
      end
      reports_ch.ready <= calm || ($urandom_range(99) >= 34);
    end
  end

  initial begin
    #400000;
    $display("timeout: %0d items and %0d lines still outstanding",
             pending_items.size(), expected_lines.size());
    $display("[tdm_slot_level_meter_core] ERROR");
    $finish;
  end

  initial begin
    int rand_samples;
    int len;
    samples_ch.valid  = 1'b0;
    samples_ch.sample = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = '0;
    cfg_ch.data       = '0;
    reports_ch.ready  = 1'b0;
    meter_reset();

    // two slots, report every frame: extremes, zero, sign changes both ways
    push_write(REG_SLOT_COUNT, 20'd2);
    push_write(REG_WINDOW, 20'd1);
    push_sample(16'h7FFF);
    push_sample(16'h8000);
    push_sample(16'h0000);
    push_sample(16'hFFFF);
    push_sample(16'h8000);
    push_sample(16'h0001);
    // zero slot count acts as one slot, zero window as one frame
    push_write(REG_SLOT_COUNT, 20'd0);
    push_write(REG_WINDOW, 20'd0);
    push_sample(16'h8000);
    push_sample(16'h7FFF);
    // slot count above the maximum saturates, upper data bits ignored
    push_write(REG_SLOT_COUNT, 20'hABCD9);
    push_write(REG_WINDOW, 20'd1);
    for (int i = 0; i < MAX_SLOTS; i++) begin
      push_sample((i % 3 == 0) ? 16'h8000 : ((i % 3 == 1) ? 16'h7FFF : 16'h0000));
    end
    // slot count lowered mid-frame, then window lowered mid-window
    push_write(REG_SLOT_COUNT, 20'd8);
    push_write(REG_WINDOW, CNT_MAX);
    for (int i = 0; i < 5; i++) begin
      push_sample(pick_sample());
    end
    push_write(REG_SLOT_COUNT, 20'd3);
    push_sample(16'h8001);
    push_write(REG_WINDOW, 20'd1);
    for (int i = 0; i < 3; i++) begin
      push_sample(pick_sample());
    end

    rand_samples = 0;
    while (rand_samples < 150) begin
      if ($urandom_range(3) != 0) begin
        push_write(REG_SLOT_COUNT, ($urandom_range(3) == 0) ?
                   {16'($urandom), pick_slots()} : {16'h0000, pick_slots()});
      end
      if ($urandom_range(2) != 0) begin
        push_write(REG_WINDOW, pick_window());
      end
      if ($urandom_range(11) == 0) begin
        push_write(($urandom_range(1) == 1) ? REG_SPARE_A : REG_SPARE_B, CFG_DATA_W'($urandom));
      end
      len = $urandom_range(4, 24);
      for (int i = 0; i < len; i++) begin
        push_sample(pick_sample());
      end
      rand_samples += len;
    end
    // a final clean window so the tail always reports
    push_write(REG_SLOT_COUNT, 20'd8);
    push_write(REG_WINDOW, 20'd1);
    for (int i = 0; i < 2 * MAX_SLOTS; i++) begin
      push_sample(pick_sample());
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (pending_items.size() != 0 || samples_ch.valid || cfg_ch.valid ||
           expected_lines.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN) @(posedge clk);

    $display("run covered %0d samples and %0d register writes, %0d report lines checked",
             n_samples, n_writes, n_lines);
    $display("slot counts 0..15 and windows from zero to the maximum, with random stalls");
    if (errors == 0 && expected_lines.size() == 0) begin
      $display("[tdm_slot_level_meter_core] OK");
    end else begin
      $display("[tdm_slot_level_meter_core] ERROR");
    end
    $finish;
  end

endmodule
